/* sv/sdts_pkg.sv */
// ----------------------------------------------------------------------------
// sdts_pkg
// Shared constants, types and command codes of the stable dependency sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package sdts_pkg;

  localparam int MAX_NODES = 64;
  localparam int MAX_EDGES = 256;
  localparam int KEY_BITS  = 32;

  // Port widths fixed by the word format
  localparam int REQ_W  = 2;
  localparam int PKEY_W = 32;
  localparam int PIDX_W = 6;
  localparam int KIND_W = 3;

  localparam int NODE_IW = $clog2(MAX_NODES);
  localparam int NODE_CW = $clog2(MAX_NODES + 1);
  localparam int EDGE_IW = $clog2(MAX_EDGES);
  localparam int EDGE_CW = $clog2(MAX_EDGES + 1);
  localparam int UNMET_W = $clog2(MAX_EDGES + 1);

  localparam logic [REQ_W-1:0] REQ_NODE   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_EDGE   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SORT   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam logic [KIND_W-1:0] KIND_NODE_ADDED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NODE_FULL  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_EDGE_OK    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DEP_MISS   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EDGE_FULL  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_ORDER      = 3'd5;
  localparam logic [KIND_W-1:0] KIND_CYCLE      = 3'd6;
  localparam logic [KIND_W-1:0] KIND_EMPTY      = 3'd7;

  typedef struct packed {
    logic [NODE_IW-1:0] dependent;
    logic [NODE_IW-1:0] dependency;
  } edge_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_NODE,
    OP_KEY_RD,
    OP_KEY_CMP,
    OP_EDGE_RES,
    OP_UNMET_INC,
    OP_EMPTY,
    OP_SCAN_INC,
    OP_SCAN_RST,
    OP_EMIT_ORDER,
    OP_EDGE_RD,
    OP_EDGE_CHK,
    OP_UNMET_DEC,
    OP_EMIT_CYCLE
  } op_e;

  typedef struct packed {
    logic out_free;
    logic scan_end;
    logic key_hit;
    logic edge_ok;
    logic empty;
    logic cand;
    logic cycle_cand;
    logic last_emit;
    logic edge_end;
    logic edge_hit;
  } status_t;

endpackage

`default_nettype wire

/* sv/sdts_dp.sv */
// ----------------------------------------------------------------------------
// sdts_dp
// Datapath: key, edge and unmet-count memories, flags, counters, output word.
// ----------------------------------------------------------------------------
`default_nettype none

module sdts_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire sdts_pkg::op_e                  op_i,
  input  wire logic [sdts_pkg::PKEY_W-1:0]    node_key_i,
  input  wire logic [sdts_pkg::PIDX_W-1:0]    dependent_index_i,
  input  wire logic                           out_ready_i,
  output sdts_pkg::status_t                   status_o,
  output logic                                out_valid_o,
  output logic [sdts_pkg::KIND_W-1:0]         result_kind_o,
  output logic [sdts_pkg::PIDX_W-1:0]         node_index_o,
  output logic                                last_o
);
  import sdts_pkg::*;

  logic [KEY_BITS-1:0] key_mem [MAX_NODES];
  edge_t               edge_mem [MAX_EDGES];
  logic [UNMET_W-1:0]  unmet_mem [MAX_NODES];

  logic [KEY_BITS-1:0] key_q, key_rd_q;
  logic [PIDX_W-1:0]   dep_q;
  edge_t               edge_rd_q;
  logic [UNMET_W-1:0]  unmet_rd_q;

  logic [NODE_CW-1:0]   node_total_q, idx_q, cnt_q;
  logic [EDGE_CW-1:0]   edge_total_q, eidx_q;
  logic [MAX_NODES-1:0] nz_q, emit_q;
  logic                 found_q;

  logic               out_valid_q, last_q;
  logic [KIND_W-1:0]  kind_q;
  logic [PIDX_W-1:0]  nidx_q;

  logic [NODE_IW-1:0] idx, dep_idx, um_waddr, um_raddr;
  logic               dep_ok, out_load, clear, um_we, um_re;
  logic [UNMET_W-1:0] um_wdata;

  assign idx     = idx_q[NODE_IW-1:0];
  assign dep_idx = dep_q[NODE_IW-1:0];
  assign dep_ok  = (7'(dep_q) < 7'(node_total_q));

  always_comb begin
    status_o.out_free   = !out_valid_q || out_ready_i;
    status_o.scan_end   = (idx_q >= node_total_q);
    status_o.key_hit    = (key_rd_q == key_q);
    status_o.edge_ok    = found_q && dep_ok && (edge_total_q < EDGE_CW'(MAX_EDGES));
    status_o.empty      = (node_total_q == '0);
    status_o.cand       = !emit_q[idx] && !nz_q[idx];
    status_o.cycle_cand = !emit_q[idx];
    status_o.last_emit  = (NODE_CW'(cnt_q + 1'b1) == node_total_q);
    status_o.edge_end   = (eidx_q >= edge_total_q);
    status_o.edge_hit   = (edge_rd_q.dependency == idx) && nz_q[edge_rd_q.dependent];
  end

  assign out_load = (op_i == OP_NODE) || (op_i == OP_EDGE_RES) || (op_i == OP_EMPTY) ||
                    (op_i == OP_EMIT_ORDER) || (op_i == OP_EMIT_CYCLE);
  assign clear    = (op_i == OP_EMPTY) ||
                    (((op_i == OP_EMIT_ORDER) || (op_i == OP_EMIT_CYCLE)) && status_o.last_emit);

  // Unmet-count port selection
  always_comb begin
    um_we    = 1'b0;
    um_re    = 1'b0;
    um_waddr = dep_idx;
    um_raddr = dep_idx;
    um_wdata = unmet_rd_q - 1'b1;
    unique case (op_i)
      OP_UNMET_INC: begin
        um_we    = 1'b1;
        um_wdata = (nz_q[dep_idx] ? unmet_rd_q : '0) + 1'b1;
      end
      OP_UNMET_DEC: begin
        um_we    = 1'b1;
        um_waddr = edge_rd_q.dependent;
      end
      OP_EDGE_RES: um_re = status_o.edge_ok;
      OP_EDGE_CHK: begin
        um_re    = status_o.edge_hit;
        um_raddr = edge_rd_q.dependent;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if ((op_i == OP_NODE) && (node_total_q < NODE_CW'(MAX_NODES))) begin
      key_mem[node_total_q[NODE_IW-1:0]] <= key_q;
    end
    if (op_i == OP_KEY_RD) begin
      key_rd_q <= key_mem[idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if ((op_i == OP_EDGE_RES) && status_o.edge_ok) begin
      edge_mem[edge_total_q[EDGE_IW-1:0]] <= '{dependent: dep_idx, dependency: idx};
    end
    if (op_i == OP_EDGE_RD) begin
      edge_rd_q <= edge_mem[eidx_q[EDGE_IW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (um_we) begin
      unmet_mem[um_waddr] <= um_wdata;
    end
    if (um_re) begin
      unmet_rd_q <= unmet_mem[um_raddr];
    end
  end

  // Captured request word
  always_ff @(posedge clk_i) begin
    if (op_i == OP_LATCH) begin
      key_q <= KEY_BITS'(node_key_i);
      dep_q <= dependent_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_total_q <= '0;
      edge_total_q <= '0;
      idx_q        <= '0;
      cnt_q        <= '0;
      eidx_q       <= '0;
      nz_q         <= '0;
      emit_q       <= '0;
      found_q      <= 1'b0;
    end else begin
      unique case (op_i)
        OP_LATCH: begin
          idx_q   <= '0;
          cnt_q   <= '0;
          found_q <= 1'b0;
        end
        OP_NODE: begin
          if (node_total_q < NODE_CW'(MAX_NODES)) node_total_q <= node_total_q + 1'b1;
        end
        OP_KEY_CMP: begin
          if (status_o.key_hit) found_q <= 1'b1;
          else                  idx_q   <= idx_q + 1'b1;
        end
        OP_EDGE_RES: begin
          if (status_o.edge_ok) edge_total_q <= edge_total_q + 1'b1;
        end
        OP_UNMET_INC: nz_q[dep_idx] <= 1'b1;
        OP_SCAN_INC:  idx_q <= idx_q + 1'b1;
        OP_SCAN_RST:  idx_q <= '0;
        OP_EMIT_ORDER: begin
          emit_q[idx] <= 1'b1;
          cnt_q       <= cnt_q + 1'b1;
          eidx_q      <= '0;
        end
        OP_EMIT_CYCLE: begin
          emit_q[idx] <= 1'b1;
          cnt_q       <= cnt_q + 1'b1;
          idx_q       <= idx_q + 1'b1;
        end
        OP_EDGE_CHK: begin
          if (!status_o.edge_hit) eidx_q <= eidx_q + 1'b1;
        end
        OP_UNMET_DEC: begin
          if (unmet_rd_q == UNMET_W'(1)) nz_q[edge_rd_q.dependent] <= 1'b0;
          eidx_q <= eidx_q + 1'b1;
        end
        default: ;
      endcase
      if (clear) begin
        node_total_q <= '0;
        edge_total_q <= '0;
        nz_q         <= '0;
        emit_q       <= '0;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      last_q <= 1'b1;
      nidx_q <= dep_q;
      unique case (op_i)
        OP_NODE: begin
          if (node_total_q < NODE_CW'(MAX_NODES)) begin
            kind_q <= KIND_NODE_ADDED;
            nidx_q <= PIDX_W'(node_total_q);
          end else begin
            kind_q <= KIND_NODE_FULL;
            nidx_q <= '0;
          end
        end
        OP_EDGE_RES: begin
          if (status_o.edge_ok)        kind_q <= KIND_EDGE_OK;
          else if (!found_q || !dep_ok) kind_q <= KIND_DEP_MISS;
          else                          kind_q <= KIND_EDGE_FULL;
        end
        OP_EMPTY: begin
          kind_q <= KIND_EMPTY;
          nidx_q <= '0;
        end
        OP_EMIT_ORDER: begin
          kind_q <= KIND_ORDER;
          nidx_q <= PIDX_W'(idx);
          last_q <= status_o.last_emit;
        end
        default: begin
          kind_q <= KIND_CYCLE;
          nidx_q <= PIDX_W'(idx);
          last_q <= status_o.last_emit;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign node_index_o  = nidx_q;
  assign last_o        = last_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> status_o.out_free) else $error("output word overwritten");
  a_dec_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_UNMET_DEC) |-> nz_q[edge_rd_q.dependent]) else $error("decrement of zero count");
  a_totals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (node_total_q <= NODE_CW'(MAX_NODES)) && (edge_total_q <= EDGE_CW'(MAX_EDGES)))
    else $error("table total out of range");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear |=> (node_total_q == '0) && (edge_total_q == '0) && (nz_q == '0) && (emit_q == '0))
    else $error("tables not cleared after sort");

endmodule

`default_nettype wire

/* sv/sdts_ctrl.sv */
// ----------------------------------------------------------------------------
// sdts_ctrl
// Controller: sequences node loads, key searches, edge records and the sort.
// ----------------------------------------------------------------------------
`default_nettype none

module sdts_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic [sdts_pkg::REQ_W-1:0]  req_type_i,
  input  wire sdts_pkg::status_t           status_i,
  output logic                             in_ready_o,
  output sdts_pkg::op_e                    op_o
);
  import sdts_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_NODE  = 13'b0000000000010,
    ST_ESCAN = 13'b0000000000100,
    ST_ECMP  = 13'b0000000001000,
    ST_ERES  = 13'b0000000010000,
    ST_EINC  = 13'b0000000100000,
    ST_SORT  = 13'b0000001000000,
    ST_PSCAN = 13'b0000010000000,
    ST_PEMIT = 13'b0000100000000,
    ST_WRD   = 13'b0001000000000,
    ST_WCHK  = 13'b0010000000000,
    ST_WDEC  = 13'b0100000000000,
    ST_CSCAN = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_o = OP_LATCH;
          priority if (req_type_i == REQ_NODE) state_d = ST_NODE;
          else if (req_type_i == REQ_EDGE)     state_d = ST_ESCAN;
          else if (req_type_i == REQ_SORT)     state_d = ST_SORT;
          else                                 state_d = ST_IDLE;
        end
      end
      ST_NODE: begin
        if (status_i.out_free) begin
          op_o    = OP_NODE;
          state_d = ST_IDLE;
        end
      end
      ST_ESCAN: begin
        if (status_i.scan_end) begin
          state_d = ST_ERES;
        end else begin
          op_o    = OP_KEY_RD;
          state_d = ST_ECMP;
        end
      end
      ST_ECMP: begin
        op_o    = OP_KEY_CMP;
        state_d = status_i.key_hit ? ST_ERES : ST_ESCAN;
      end
      ST_ERES: begin
        if (status_i.out_free) begin
          op_o    = OP_EDGE_RES;
          state_d = status_i.edge_ok ? ST_EINC : ST_IDLE;
        end
      end
      ST_EINC: begin
        op_o    = OP_UNMET_INC;
        state_d = ST_IDLE;
      end
      ST_SORT: begin
        if (!status_i.empty) begin
          state_d = ST_PSCAN;
        end else if (status_i.out_free) begin
          op_o    = OP_EMPTY;
          state_d = ST_IDLE;
        end
      end
      ST_PSCAN: begin
        if (status_i.scan_end) begin
          op_o    = OP_SCAN_RST;
          state_d = ST_CSCAN;
        end else if (status_i.cand) begin
          state_d = ST_PEMIT;
        end else begin
          op_o = OP_SCAN_INC;
        end
      end
      ST_PEMIT: begin
        if (status_i.out_free) begin
          op_o    = OP_EMIT_ORDER;
          state_d = status_i.last_emit ? ST_IDLE : ST_WRD;
        end
      end
      ST_WRD: begin
        if (status_i.edge_end) begin
          op_o    = OP_SCAN_RST;
          state_d = ST_PSCAN;
        end else begin
          op_o    = OP_EDGE_RD;
          state_d = ST_WCHK;
        end
      end
      ST_WCHK: begin
        op_o    = OP_EDGE_CHK;
        state_d = status_i.edge_hit ? ST_WDEC : ST_WRD;
      end
      ST_WDEC: begin
        op_o    = OP_UNMET_DEC;
        state_d = ST_WRD;
      end
      ST_CSCAN: begin
        if (!status_i.cycle_cand) begin
          op_o = OP_SCAN_INC;
        end else if (status_i.out_free) begin
          op_o    = OP_EMIT_CYCLE;
          state_d = status_i.last_emit ? ST_IDLE : ST_CSCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state register not one-hot");
  a_walk_cand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PEMIT) |-> status_i.cand) else $error("picked node not ready");
  a_cscan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CSCAN) |-> !status_i.scan_end) else $error("cycle scan ran past last node");

endmodule

`default_nettype wire

/* sv/stable_dependency_topo_sort.sv */
// Edge add: scan the stored keys in order for the given key, then record the edge or
//   report why not, and raise the dependent's unmet count when it is recorded.
// Sort: per emitted node a scan for the first ready node, an emit, a walk over the
//   stored edges lowering counts, then a restart; then cycle entries, skipping emitted ones.
// Requests: one item at a time, taken only when idle.
// Reset: asynchronous, active low; clears totals, counters, flags, state and output valid only.
// ----------------------------------------------------------------------------
// stable_dependency_topo_sort
// Stable Kahn topological sorter: loads keyed nodes and edges, emits an order or cycle entries.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_dependency_topo_sort (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // request words
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [sdts_pkg::REQ_W-1:0]  req_type_i,
  input  wire logic [sdts_pkg::PKEY_W-1:0] node_key_i,
  input  wire logic [sdts_pkg::PIDX_W-1:0] dependent_index_i,
  // result words
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [sdts_pkg::KIND_W-1:0]      result_kind_o,
  output logic [sdts_pkg::PIDX_W-1:0]      node_index_o,
  output logic                             last_o
);
  import sdts_pkg::*;

  op_e     op;
  status_t status;

  // Controller: decide at most one datapath operation per cycle from the status flags
  sdts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .op_o       (op)
  );

  // Datapath: hold the tables and the output word register, which lets the
  // controller move on while a result word waits for the consumer
  sdts_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .op_i              (op),
    .node_key_i        (node_key_i),
    .dependent_index_i (dependent_index_i),
    .out_ready_i       (out_ready_i),
    .status_o          (status),
    .out_valid_o       (out_valid_o),
    .result_kind_o     (result_kind_o),
    .node_index_o      (node_index_o),
    .last_o            (last_o)
  );

endmodule

`default_nettype wire
